FILE: hdl/affh_pkg.sv
// Shared constants, codes and types for the ADC frame parser with flow hysteresis.
// No dependencies; every other file imports this package.
package affh_pkg;

  localparam int CHANNELS      = 6;
  localparam int FRAME_BYTES   = 16;
  localparam int FILL_W        = $clog2(FRAME_BYTES + 1);
  localparam int BYTE_W        = 8;
  localparam int CHAN_W        = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int SPAN_W        = 15;
  localparam int PROD_W        = SPAN_W + CHAN_W;
  localparam int QUOT_W        = 24;
  localparam int FRAC_W        = 8;
  localparam int DVD_W         = PROD_W + FRAC_W;
  localparam int RECIP_W       = 26;
  localparam int RECIP_SHIFT   = 31;
  localparam int MULR_W        = PROD_W + RECIP_W;
  localparam int CNT_W         = 32;

  // Loop current spans in microamps
  localparam logic [CHAN_W-1:0] LOWER_LIVE = 16'd4000;
  localparam logic [SPAN_W-1:0] SPAN_FULL  = 15'd20000;
  localparam logic [SPAN_W-1:0] SPAN_LIVE  = 15'd16000;

  // floor(2^39 / span): 256 / span scaled by 2^31
  localparam logic [RECIP_W-1:0] RECIP_FULL = 26'd27487790;
  localparam logic [RECIP_W-1:0] RECIP_LIVE = 26'd34359738;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIVE_ZERO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_THR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THR   = 3'd7;

  // Result kinds and flow edge codes
  localparam logic       KIND_FRAME   = 1'b0;
  localparam logic       KIND_NOFRAME = 1'b1;
  localparam logic [1:0] EDGE_NONE    = 2'd0;
  localparam logic [1:0] EDGE_START   = 2'd1;
  localparam logic [1:0] EDGE_STOP    = 2'd2;

  typedef struct packed {
    logic              start;
    logic              live_zero;
    logic [CHAN_W-1:0] chan;
    logic [CHAN_W-1:0] full_scale;
  } scale_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic              exact;
  } scale_rsp_t;

endpackage

FILE: hdl/affh_chan_if.sv
// Handshake channels of the frame parser: byte input, result output, register writes.
// Depends on affh_pkg.
interface affh_in_if;
  import affh_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              chunk_end;
  modport source (output valid, rx_byte, chunk_end, input ready);
  modport sink (input valid, rx_byte, chunk_end, output ready);
endinterface

interface affh_out_if;
  import affh_pkg::*;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [CHAN_W-1:0] chan_one;
  logic [CHAN_W-1:0] chan_two;
  logic [CHAN_W-1:0] chan_three;
  logic [CHAN_W-1:0] chan_four;
  logic [CHAN_W-1:0] chan_five;
  logic [CHAN_W-1:0] chan_six;
  logic [QUOT_W-1:0] flow_q8;
  logic              flow_on;
  logic [1:0]        flow_edge;
  logic [CNT_W-1:0]  frame_total;
  logic [CNT_W-1:0]  error_total;
  modport source (output valid, result_kind, chan_one, chan_two, chan_three, chan_four,
                  chan_five, chan_six, flow_q8, flow_on, flow_edge, frame_total,
                  error_total, input ready);
  modport sink (input valid, result_kind, chan_one, chan_two, chan_three, chan_four,
                chan_five, chan_six, flow_q8, flow_on, flow_edge, frame_total,
                error_total, output ready);
endinterface

interface affh_cfg_if;
  import affh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/affh_cell.sv
// One byte cell of the sliding frame window; takes its neighbor's byte on each shift.
// Depends on affh_pkg.
module affh_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [affh_pkg::BYTE_W-1:0] byte_i,
  output logic [affh_pkg::BYTE_W-1:0] byte_o
);
  import affh_pkg::*;

  logic [BYTE_W-1:0] byte_q, byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;
  assign byte_o = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

FILE: hdl/affh_scale.sv
// Flow scaler: clamps the loop current, multiplies by full scale and divides by the
// span through a reciprocal multiply and one correction step. Depends on affh_pkg.
module affh_scale (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  affh_pkg::scale_req_t    req_i,
  output affh_pkg::scale_rsp_t    rsp_o
);
  import affh_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL  = 3'd1;
  localparam logic [2:0] P_REC  = 3'd2;
  localparam logic [2:0] P_BACK = 3'd3;
  localparam logic [2:0] P_REM  = 3'd4;
  localparam logic [2:0] P_FIX  = 3'd5;

  logic [2:0]         phase_q, phase_d;
  logic               done_q, done_d;
  logic [SPAN_W-1:0]  num_q, num_d;
  logic [SPAN_W-1:0]  span_q, span_d;
  logic [RECIP_W-1:0] recip_q, recip_d;
  logic [CHAN_W-1:0]  fs_q, fs_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [QUOT_W-1:0]  quot_q, quot_d;
  logic [DVD_W-1:0]   back_q, back_d;
  logic [SPAN_W:0]    rem_q, rem_d;

  logic [CHAN_W-1:0]  lower;
  logic [SPAN_W-1:0]  span_sel;
  logic [CHAN_W-1:0]  diff;
  logic [PROD_W-1:0]  prod;
  logic [MULR_W-1:0]  est;
  logic [DVD_W-1:0]   back;
  logic [DVD_W-1:0]   rem_full;

  always_comb begin
    lower    = req_i.live_zero ? LOWER_LIVE : '0;
    span_sel = req_i.live_zero ? SPAN_LIVE : SPAN_FULL;
    diff     = (req_i.chan > lower) ? (req_i.chan - lower) : '0;
  end

  assign prod     = PROD_W'(num_q) * PROD_W'(fs_q);
  // prod stays below 2^31, so the estimate is the quotient or one less
  assign est      = MULR_W'(prod_q) * MULR_W'(recip_q);
  assign back     = DVD_W'(quot_q) * DVD_W'(span_q);
  assign rem_full = {prod_q, {FRAC_W{1'b0}}} - back_q;

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    num_d   = num_q;
    span_d  = span_q;
    recip_d = recip_q;
    fs_d    = fs_q;
    prod_d  = prod_q;
    quot_d  = quot_q;
    back_d  = back_q;
    rem_d   = rem_q;
    case (phase_q)
      P_IDLE: begin
        if (req_i.start) begin
          num_d   = (diff > CHAN_W'(span_sel)) ? span_sel : diff[SPAN_W-1:0];
          span_d  = span_sel;
          recip_d = req_i.live_zero ? RECIP_LIVE : RECIP_FULL;
          fs_d    = req_i.full_scale;
          phase_d = P_MUL;
        end
      end
      P_MUL: begin
        prod_d  = prod;
        phase_d = P_REC;
      end
      P_REC: begin
        quot_d  = est[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        phase_d = P_BACK;
      end
      P_BACK: begin
        back_d  = back;
        phase_d = P_REM;
      end
      P_REM: begin
        // Remainder of prod * 256 sits below twice the span
        rem_d   = rem_full[SPAN_W:0];
        phase_d = P_FIX;
      end
      P_FIX: begin
        if (rem_q >= {1'b0, span_q}) begin
          quot_d = quot_q + 1'b1;
          rem_d  = rem_q - {1'b0, span_q};
        end
        done_d  = 1'b1;
        phase_d = P_IDLE;
      end
      default: begin
        phase_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    span_q  <= span_d;
    recip_q <= recip_d;
    fs_q    <= fs_d;
    prod_q  <= prod_d;
    quot_q  <= quot_d;
    back_q  <= back_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.quot  = quot_q;
  assign rsp_o.exact = (rem_q == '0) && (quot_q[FRAC_W-1:0] == '0);

endmodule

FILE: hdl/adc_frame_flow_hysteresis_core.sv
// Frame parser for a six-channel current-loop ADC with flow scaling and hysteresis.
// An error word passes the window check and the output load; a frame word passes the
// window check, the scaler's multiply, reciprocal, back, remainder and fix phases, its
// done flag and output load. No new byte is taken until the last has left the check and
// any output load, which waits on a held result word. Reset (rst_ni low, async) clears
// all but the payload registers; depends on affh_pkg, affh_cell, affh_scale.
module adc_frame_flow_hysteresis_core (
  input  logic clk_i,
  input  logic rst_ni,
  affh_in_if.sink     in_ch,
  affh_out_if.source  out_ch,
  affh_cfg_if.sink    cfg_ch
);
  import affh_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);

  // Configuration registers
  logic [BYTE_W-1:0] head_one_q, head_two_q, tail_one_q, tail_two_q;
  logic              live_zero_q;
  logic [CHAN_W-1:0] full_scale_q, start_thr_q, stop_thr_q;

  logic [1:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              matched_q, matched_d;
  logic              last_q, last_d;
  logic              active_q, active_d;
  logic [CNT_W-1:0]  frames_q, frames_d;
  logic [CNT_W-1:0]  errors_q, errors_d;
  logic              kind_q, kind_d;
  logic [QUOT_W-1:0] quot_q;
  logic              exact_q;
  logic [CHAN_W-1:0] chan_q [CHANNELS];

  logic              out_valid_q, out_valid_d;
  logic              out_kind_q;
  logic [CHAN_W-1:0] out_chan_q [CHANNELS];
  logic [QUOT_W-1:0] out_flow_q;
  logic              out_on_q;
  logic [1:0]        out_edge_q;
  logic [CNT_W-1:0]  out_frames_q, out_errors_q;

  logic [BYTE_W-1:0] win [FRAME_BYTES];
  logic              in_fire, shift, is_frame, no_frame, load, capture;
  logic [1:0]        edge_d;
  logic [CHAN_W-1:0] q_int;
  logic              stop_hit;
  scale_req_t        req;
  scale_rsp_t        rsp;

  assign in_ch.ready  = (state_q == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign shift        = in_fire;
  assign cfg_ch.ready = 1'b1;

  // Window: cell 0 holds the oldest byte, the newest enters at the far end
  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    logic [BYTE_W-1:0] feed;
    if (i == FRAME_BYTES - 1) begin : g_end
      assign feed = in_ch.rx_byte;
    end else begin : g_mid
      assign feed = win[i+1];
    end
    affh_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .byte_i  (feed),
      .byte_o  (win[i])
    );
  end

  assign is_frame = (fill_q == FILL_FULL) && !matched_q &&
                    (win[0] == head_one_q) && (win[1] == head_two_q) &&
                    (win[FRAME_BYTES-2] == tail_one_q) && (win[FRAME_BYTES-1] == tail_two_q);
  assign no_frame = last_q && (fill_q == FILL_FULL) && !matched_q;
  assign capture  = (state_q == S_CHECK) && is_frame;

  assign req.start      = capture;
  assign req.live_zero  = live_zero_q;
  assign req.chan       = {win[2*CHANNELS], win[2*CHANNELS+1]};
  assign req.full_scale = full_scale_q;

  affh_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign load     = (state_q == S_EMIT) && (!out_valid_q || out_ch.ready);
  assign q_int    = quot_q[QUOT_W-1:FRAC_W];
  assign stop_hit = (q_int < stop_thr_q) || ((q_int == stop_thr_q) && exact_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    matched_d   = matched_q;
    last_d      = last_q;
    active_d    = active_q;
    frames_d    = frames_q;
    errors_d    = errors_q;
    kind_d      = kind_q;
    edge_d      = EDGE_NONE;
    out_valid_d = out_valid_q && !out_ch.ready;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          last_d  = in_ch.chunk_end;
          fill_d  = (fill_q < FILL_FULL) ? fill_q + 1'b1 : fill_q;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (is_frame) begin
          matched_d = 1'b1;
          kind_d    = KIND_FRAME;
          state_d   = S_CALC;
        end else if (no_frame) begin
          kind_d  = KIND_NOFRAME;
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
        // Windows never span two chunks
        if (last_q) begin
          fill_d    = '0;
          matched_d = 1'b0;
        end
      end
      S_CALC: begin
        if (rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (kind_q == KIND_FRAME) begin
            frames_d = frames_q + 1'b1;
            if (!active_q && (q_int >= start_thr_q)) begin
              active_d = 1'b1;
              edge_d   = EDGE_START;
            end else if (active_q && stop_hit) begin
              active_d = 1'b0;
              edge_d   = EDGE_STOP;
            end
          end else begin
            errors_d = errors_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      matched_q    <= 1'b0;
      last_q       <= 1'b0;
      active_q     <= 1'b0;
      frames_q     <= '0;
      errors_q     <= '0;
      kind_q       <= KIND_FRAME;
      out_valid_q  <= 1'b0;
      head_one_q   <= '0;
      head_two_q   <= '0;
      tail_one_q   <= '0;
      tail_two_q   <= '0;
      live_zero_q  <= 1'b0;
      full_scale_q <= '0;
      start_thr_q  <= '0;
      stop_thr_q   <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      matched_q   <= matched_d;
      last_q      <= last_d;
      active_q    <= active_d;
      frames_q    <= frames_d;
      errors_q    <= errors_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_HEAD_ONE:   head_one_q   <= cfg_ch.data[BYTE_W-1:0];
          REG_HEAD_TWO:   head_two_q   <= cfg_ch.data[BYTE_W-1:0];
          REG_TAIL_ONE:   tail_one_q   <= cfg_ch.data[BYTE_W-1:0];
          REG_TAIL_TWO:   tail_two_q   <= cfg_ch.data[BYTE_W-1:0];
          REG_LIVE_ZERO:  live_zero_q  <= cfg_ch.data[0];
          REG_FULL_SCALE: full_scale_q <= cfg_ch.data;
          REG_START_THR:  start_thr_q  <= cfg_ch.data;
          REG_STOP_THR:   stop_thr_q   <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (capture) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_q[i] <= {win[2+2*i], win[3+2*i]};
      end
    end
    if (rsp.done) begin
      quot_q  <= rsp.quot;
      exact_q <= rsp.exact;
    end
    if (load) begin
      out_kind_q   <= kind_q;
      out_on_q     <= active_d;
      out_edge_q   <= edge_d;
      out_frames_q <= frames_d;
      out_errors_q <= errors_d;
      if (kind_q == KIND_FRAME) begin
        out_flow_q <= quot_q;
        for (int i = 0; i < CHANNELS; i++) begin
          out_chan_q[i] <= chan_q[i];
        end
      end else begin
        out_flow_q <= '0;
        for (int i = 0; i < CHANNELS; i++) begin
          out_chan_q[i] <= '0;
        end
      end
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.result_kind = out_kind_q;
  assign out_ch.chan_one    = out_chan_q[0];
  assign out_ch.chan_two    = out_chan_q[1];
  assign out_ch.chan_three  = out_chan_q[2];
  assign out_ch.chan_four   = out_chan_q[3];
  assign out_ch.chan_five   = out_chan_q[4];
  assign out_ch.chan_six    = out_chan_q[5];
  assign out_ch.flow_q8     = out_flow_q;
  assign out_ch.flow_on     = out_on_q;
  assign out_ch.flow_edge   = out_edge_q;
  assign out_ch.frame_total = out_frames_q;
  assign out_ch.error_total = out_errors_q;

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_CHECK))
    else $error("accepted word not followed by window check");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_CALC))
    else $error("scaler finished outside of calculation");

  a_nofrcame_no_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.result_kind == KIND_NOFRAME)) |->
      (out_ch.flow_edge == EDGE_NONE))
    else $error("chunk error result carries a flow edge");

  a_edge_matches_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.flow_edge != EDGE_NONE)) |->
      (out_ch.flow_on == (out_ch.flow_edge == EDGE_START)))
    else $error("flow edge disagrees with active flag");

endmodule

FILE: sim/affh_result_checker.sv
`timescale 1ns / 1ps
// Scoreboard for adc_frame_flow_hysteresis_core: mirrors register writes and accepted bytes,
// predicts every frame and no-frame word, and compares it with the result channel.
// Depends on affh_pkg and the channel interfaces of affh_chan_if.
module affh_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  affh_in_if   in_ch,
  affh_out_if  out_ch,
  affh_cfg_if  cfg_ch,
  output int   fail_count_o,
  output int   pending_o
);
  import affh_pkg::*;

  typedef struct packed {
    logic                            kind;
    logic [CHANNELS-1:0][CHAN_W-1:0] chans;
    logic [QUOT_W-1:0]               flow_q8;
    logic                            flow_on;
    logic [1:0]                      flow_edge;
    logic [CNT_W-1:0]                frame_total;
    logic [CNT_W-1:0]                error_total;
  } flow_report_t;

  // Register shadow
  logic [BYTE_W-1:0] head_one, head_two, tail_one, tail_two;
  logic              live_zero;
  logic [CHAN_W-1:0] full_scale, start_thr, stop_thr;

  // Parser state
  logic [BYTE_W-1:0] window [FRAME_BYTES];
  int unsigned       fill;
  bit                matched;
  bit                flow_flag;
  logic [CNT_W-1:0]  frames_seen, errors_seen;

  flow_report_t expected_reports [$];
  int           fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic void parse_byte(input logic [BYTE_W-1:0] rx, input logic last);
    flow_report_t    rep;
    longint unsigned lower, span, num, prod;
    bit              hit;
    for (int i = 0; i < FRAME_BYTES - 1; i++) window[i] = window[i + 1];
    window[FRAME_BYTES - 1] = rx;
    if (fill < FRAME_BYTES) fill++;
    hit = fill >= FRAME_BYTES && !matched &&
          window[0] == head_one && window[1] == head_two &&
          window[FRAME_BYTES - 2] == tail_one && window[FRAME_BYTES - 1] == tail_two;
    rep = '0;
    if (hit) begin
      for (int i = 0; i < CHANNELS; i++) rep.chans[i] = {window[2 + 2 * i], window[3 + 2 * i]};
      lower = live_zero ? LOWER_LIVE : 0;
      span  = live_zero ? SPAN_LIVE : SPAN_FULL;
      num   = (rep.chans[CHANNELS - 1] > lower) ? rep.chans[CHANNELS - 1] - lower : 0;
      if (num > span) num = span;
      prod = num * full_scale;
      matched = 1'b1;
      frames_seen++;
      rep.kind      = KIND_FRAME;
      rep.flow_edge = EDGE_NONE;
      // thresholds compare against the exact quotient, so scale them by the span
      if (!flow_flag && prod >= start_thr * span) begin
        flow_flag     = 1'b1;
        rep.flow_edge = EDGE_START;
      end else if (flow_flag && prod <= stop_thr * span) begin
        flow_flag     = 1'b0;
        rep.flow_edge = EDGE_STOP;
      end
      rep.flow_q8     = QUOT_W'((prod * 256) / span);
      rep.flow_on     = flow_flag;
      rep.frame_total = frames_seen;
      rep.error_total = errors_seen;
      expected_reports.push_back(rep);
    end else if (last && fill >= FRAME_BYTES && !matched) begin
      errors_seen++;
      rep.kind        = KIND_NOFRAME;
      rep.flow_on     = flow_flag;
      rep.frame_total = frames_seen;
      rep.error_total = errors_seen;
      expected_reports.push_back(rep);
    end
    if (last) begin
      fill    = 0;
      matched = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    flow_report_t got, want;
    if (!rst_ni) begin
      head_one    <= '0;
      head_two    <= '0;
      tail_one    <= '0;
      tail_two    <= '0;
      live_zero   <= 1'b0;
      full_scale  <= '0;
      start_thr   <= '0;
      stop_thr    <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) window[i] = '0;
      fill        = 0;
      matched     = 1'b0;
      flow_flag   = 1'b0;
      frames_seen = '0;
      errors_seen = '0;
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_HEAD_ONE:   head_one   <= cfg_ch.data[BYTE_W-1:0];
          REG_HEAD_TWO:   head_two   <= cfg_ch.data[BYTE_W-1:0];
          REG_TAIL_ONE:   tail_one   <= cfg_ch.data[BYTE_W-1:0];
          REG_TAIL_TWO:   tail_two   <= cfg_ch.data[BYTE_W-1:0];
          REG_LIVE_ZERO:  live_zero  <= cfg_ch.data[0];
          REG_FULL_SCALE: full_scale <= cfg_ch.data;
          REG_START_THR:  start_thr  <= cfg_ch.data;
          REG_STOP_THR:   stop_thr   <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.rx_byte, in_ch.chunk_end);
      if (out_ch.valid && out_ch.ready) begin
        got.kind        = out_ch.result_kind;
        got.chans[0]    = out_ch.chan_one;
        got.chans[1]    = out_ch.chan_two;
        got.chans[2]    = out_ch.chan_three;
        got.chans[3]    = out_ch.chan_four;
        got.chans[4]    = out_ch.chan_five;
        got.chans[5]    = out_ch.chan_six;
        got.flow_q8     = out_ch.flow_q8;
        got.flow_on     = out_ch.flow_on;
        got.flow_edge   = out_ch.flow_edge;
        got.frame_total = out_ch.frame_total;
        got.error_total = out_ch.error_total;
        if (expected_reports.size() == 0) begin
          $display("%0t: result word of kind %0d arrived with none expected",
                   $time, got.kind);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("result_kind", want.kind, got.kind);
          for (int i = 0; i < CHANNELS; i++)
            check_field($sformatf("chan %0d", i + 1), want.chans[i], got.chans[i]);
          check_field("flow_q8", want.flow_q8, got.flow_q8);
          check_field("flow_on", want.flow_on, got.flow_on);
          check_field("flow_edge", want.flow_edge, got.flow_edge);
          check_field("frame_total", want.frame_total, got.frame_total);
          check_field("error_total", want.error_total, got.error_total);
        end
      end
      pending_o <= expected_reports.size();
    end
  end

endmodule

FILE: sim/adc_frame_flow_hysteresis_core_test.sv
`timescale 1ns / 1ps
// Testbench top for adc_frame_flow_hysteresis_core: drives byte chunks, register phases and
// result back-pressure; affh_result_checker does prediction. Depends on affh_pkg, the interfaces.
module adc_frame_flow_hysteresis_core_test;
  import affh_pkg::*;

  localparam int RANDOM_BYTES  = 1200;
  localparam int PHASES        = 6;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {
    CHUNK_FRAME, CHUNK_FRAME_AT_END, CHUNK_TWO_FRAMES, CHUNK_SPLIT,
    CHUNK_BROKEN, CHUNK_NOISE, CHUNK_SHORT
  } chunk_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   phase_no   = 0;
  bit   calm       = 1'b0;
  bit   hold_done  = 1'b0;
  int   bytes_sent = 0;
  int   gap_odds   = 0;

  // marker bytes and span mode currently programmed, used to build frames
  logic [BYTE_W-1:0] mark_head_one, mark_head_two, mark_tail_one, mark_tail_two;
  logic              live_zero_set;

  affh_in_if  in_ch ();
  affh_out_if out_ch ();
  affh_cfg_if cfg_ch ();

  adc_frame_flow_hysteresis_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  affh_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin : watchdog
    #5_000_000;
    $display("** adc_frame_flow_hysteresis_core: FAILED **");
    $finish;
  end

  // Result side: random stalls, one long hold-off, none in the calm phase
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!hold_done && phase_no == HOLD_PHASE) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Leave valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic last);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= rx;
    in_ch.chunk_end <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_noise(input int count, input bit end_chunk);
    for (int i = 0; i < count; i++)
      send_byte(BYTE_W'($urandom_range(0, 255)), end_chunk && i == count - 1);
  endtask

  function automatic logic [CHAN_W-1:0] pick_loop_current();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return LOWER_LIVE - 16'd1;
      2:       return LOWER_LIVE;
      3:       return 16'd20000;
      4:       return 16'd20001;
      5:       return 16'hFFFF;
      default: return CHAN_W'($urandom_range(0, 21000));
    endcase
  endfunction

  // end_at: byte index that carries chunk_end, -1 for none
  task automatic send_frame(input int end_at, input bit broken);
    logic [BYTE_W-1:0] fb [FRAME_BYTES];
    logic [CHAN_W-1:0] w;
    int                spot;
    fb[0]               = mark_head_one;
    fb[1]               = mark_head_two;
    fb[FRAME_BYTES - 2] = mark_tail_one;
    fb[FRAME_BYTES - 1] = mark_tail_two;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i == CHANNELS - 1) w = pick_loop_current();
      else case ($urandom_range(0, 5))
        0:       w = 16'h0000;
        1:       w = 16'hFFFF;
        default: w = CHAN_W'($urandom);
      endcase
      fb[2 + 2 * i] = w[15:8];
      fb[3 + 2 * i] = w[7:0];
    end
    if (broken) begin
      case ($urandom_range(0, 3))
        0:       spot = 0;
        1:       spot = 1;
        2:       spot = FRAME_BYTES - 2;
        default: spot = FRAME_BYTES - 1;
      endcase
      fb[spot] = fb[spot] ^ BYTE_W'($urandom_range(1, 255));
    end
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[i], i == end_at);
  endtask

  task automatic send_chunk();
    chunk_kind_e kind;
    int          r;
    r = $urandom_range(0, 19);
    if (r < 7)       kind = CHUNK_FRAME;
    else if (r < 10) kind = CHUNK_FRAME_AT_END;
    else if (r < 12) kind = CHUNK_TWO_FRAMES;
    else if (r < 14) kind = CHUNK_SPLIT;
    else if (r < 16) kind = CHUNK_BROKEN;
    else if (r < 18) kind = CHUNK_NOISE;
    else             kind = CHUNK_SHORT;
    gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
    case (kind)
      CHUNK_FRAME: begin
        send_noise($urandom_range(0, 6), 1'b0);
        send_frame(-1, 1'b0);
        send_noise($urandom_range(1, 6), 1'b1);
      end
      CHUNK_FRAME_AT_END: begin
        send_noise($urandom_range(0, 6), 1'b0);
        send_frame(FRAME_BYTES - 1, 1'b0);
      end
      CHUNK_TWO_FRAMES: begin
        // second match in the chunk must be dropped
        send_noise($urandom_range(0, 3), 1'b0);
        send_frame(-1, 1'b0);
        send_noise($urandom_range(0, 3), 1'b0);
        send_frame(FRAME_BYTES - 1, 1'b0);
      end
      CHUNK_SPLIT: begin
        send_noise($urandom_range(0, 4), 1'b0);
        send_frame($urandom_range(3, 12), 1'b0);
        send_noise($urandom_range(1, 6), 1'b1);
      end
      CHUNK_BROKEN: begin
        send_noise($urandom_range(0, 4), 1'b0);
        send_frame(-1, 1'b1);
        send_noise($urandom_range(1, 6), 1'b1);
      end
      CHUNK_NOISE: send_noise($urandom_range(16, 30), 1'b1);
      default:     send_noise($urandom_range(1, FRAME_BYTES - 1), 1'b1);
    endcase
  endtask

  task automatic configure(input int p);
    logic [CHAN_W-1:0] fs, st, sp;
    case (p)
      1: begin
        mark_head_one = 8'hFF; mark_head_two = 8'hFF;
        mark_tail_one = 8'hFF; mark_tail_two = 8'hFF;
        live_zero_set = 1'b1;
        fs = 16'hFFFF; st = 16'hFFFF; sp = 16'h0000;
      end
      2: begin
        // start at zero and stop at max: the flag toggles on every frame
        mark_head_one = 8'h00; mark_head_two = 8'hFF;
        mark_tail_one = 8'hFF; mark_tail_two = 8'h00;
        live_zero_set = 1'b0;
        fs = 16'h0000; st = 16'h0000; sp = 16'hFFFF;
      end
      default: begin
        mark_head_one = BYTE_W'($urandom); mark_head_two = BYTE_W'($urandom);
        mark_tail_one = BYTE_W'($urandom); mark_tail_two = BYTE_W'($urandom);
        live_zero_set = 1'($urandom);
        fs = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, 255)) : CHAN_W'($urandom);
        st = CHAN_W'($urandom_range(0, fs));
        sp = CHAN_W'($urandom_range(0, st));
      end
    endcase
    // random upper bits on the narrow registers must be ignored
    write_reg(REG_HEAD_ONE, {8'($urandom), mark_head_one});
    write_reg(REG_HEAD_TWO, {8'($urandom), mark_head_two});
    write_reg(REG_TAIL_ONE, {8'($urandom), mark_tail_one});
    write_reg(REG_TAIL_TWO, {8'($urandom), mark_tail_two});
    write_reg(REG_LIVE_ZERO, {15'($urandom), live_zero_set});
    write_reg(REG_FULL_SCALE, fs);
    write_reg(REG_START_THR, st);
    write_reg(REG_STOP_THR, sp);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait out every expected word, then the in-flight bytes that give none
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [CHAN_W-1:0] words [CHANNELS];
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.rx_byte   <= '0;
    in_ch.chunk_end <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_HEAD_ONE;
    cfg_ch.data     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all-zero markers, frame on the last byte of its chunk, then a short chunk
    mark_head_one = '0; mark_head_two = '0;
    mark_tail_one = '0; mark_tail_two = '0;
    live_zero_set = 1'b0;
    words = '{16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00, 16'h8001, 16'h0000};
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    foreach (words[i]) begin
      send_byte(words[i][15:8], 1'b0);
      send_byte(words[i][7:0], 1'b0);
    end
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain();

    for (int p = 1; p <= PHASES; p++) begin
      phase_no = p;
      calm     = (p == PHASES);
      configure(p);
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES / PHASES) send_chunk();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("** adc_frame_flow_hysteresis_core: PASSED **");
    end else begin
      $display("** adc_frame_flow_hysteresis_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/affh_pkg.sv
hdl/affh_chan_if.sv
hdl/affh_cell.sv
hdl/affh_scale.sv
hdl/adc_frame_flow_hysteresis_core.sv
sim/affh_result_checker.sv
sim/adc_frame_flow_hysteresis_core_test.sv
